FILE: design/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared field widths, request and status codes, and the per-cell control
// word broadcast along the cell chain.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_READ   = 3'd2,
    MODE_INSERT = 3'd3,
    MODE_DELETE = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic                     open_gap;
    logic                     close_gap;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: design/ple_if.sv
// ----------------------------------------------------------------------------
// Positional list engine channels
// Valid/ready channels for the request and the response of the engine.
// ----------------------------------------------------------------------------
interface ple_req_if;
  logic                             valid;
  logic                             ready;
  logic [ple_pkg::MODE_W-1:0]       mode;
  logic [ple_pkg::POS_W-1:0]        position;
  logic signed [ple_pkg::DATA_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface ple_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [ple_pkg::DATA_W-1:0] read_value;
  logic [ple_pkg::STAT_W-1:0]        status;
  logic [ple_pkg::CNT_OUT_W-1:0]     entry_count;

  modport source (output valid, output read_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  output ready);
endinterface

FILE: design/ple_cell.sv
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry. Opens or closes a gap by taking its neighbor's word or,
// at the gap, the new value, and drives its word onto the read bus when selected.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int unsigned AT_W  = 5,
  parameter int unsigned INDEX = 0
) (
  input  logic                              clk_i,
  input  ple_pkg::cell_ctrl_t               ctrl_i,
  input  logic [AT_W-1:0]                   at_i,
  input  logic signed [ple_pkg::DATA_W-1:0] left_i,
  input  logic signed [ple_pkg::DATA_W-1:0] right_i,
  output logic signed [ple_pkg::DATA_W-1:0] data_o,
  output logic signed [ple_pkg::DATA_W-1:0] rd_o
);

  localparam logic [AT_W-1:0] MyIdx = AT_W'(INDEX);

  logic signed [ple_pkg::DATA_W-1:0] data_q;
  logic signed [ple_pkg::DATA_W-1:0] data_d;
  logic                              hit;
  logic                              beyond;

  assign hit    = (at_i == MyIdx);
  assign beyond = (MyIdx > at_i);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.open_gap) begin
      if (hit) begin
        data_d = ctrl_i.value;
      end else if (beyond) begin
        data_d = left_i;
      end
    end else if (ctrl_i.close_gap) begin
      if (hit || beyond) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = hit ? data_q : '0;

endmodule

FILE: design/positional_list_engine_unit.sv
// A response is registered when its request is accepted and is valid in the cycle after.
// One request per cycle while the response side keeps up; all affected cells shift at once.
// A new request is taken while the response register is empty or being drained.
// Reset clears the entry count and the response valid; entry words stay undefined.
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed words kept in a chain of cells, with push, pop,
// positional read, insert and delete requests.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ple_req_if.sink         req_i,
  ple_rsp_if.source       rsp_o
);

  localparam int unsigned CIDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned AT_W   = (CIDX_W > ple_pkg::POS_W) ? CIDX_W : ple_pkg::POS_W;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;
  localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]                  count_q;
  logic [CNT_W-1:0]                  count_d;
  logic                              rsp_valid_q;
  logic signed [ple_pkg::DATA_W-1:0] rsp_value_q;
  logic [ple_pkg::STAT_W-1:0]        rsp_status_q;
  logic [ple_pkg::CNT_OUT_W-1:0]     rsp_count_q;

  logic                              accept;
  logic                              in_range;
  logic                              full;
  logic                              empty;
  logic [AT_W-1:0]                   pos_at;
  logic [AT_W-1:0]                   at;
  ple_pkg::cell_ctrl_t               ctrl;
  ple_pkg::status_e                  status;
  logic                              do_read;
  logic signed [ple_pkg::DATA_W-1:0] read_bus;
  logic signed [ple_pkg::DATA_W-1:0] read_value;

  logic signed [ple_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic signed [ple_pkg::DATA_W-1:0] cell_rd   [CAPACITY];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign in_range = (req_i.position != '0) &&
                    (CMP_W'(req_i.position) <= CMP_W'(count_q));
  assign full     = (count_q == CapCount);
  assign empty    = (count_q == '0);
  assign pos_at   = AT_W'(req_i.position) - AT_W'(1);

  always_comb begin
    status         = ple_pkg::STAT_OK;
    count_d        = count_q;
    at             = '0;
    do_read        = 1'b0;
    ctrl.open_gap  = 1'b0;
    ctrl.close_gap = 1'b0;
    ctrl.value     = req_i.value;
    unique case (ple_pkg::mode_e'(req_i.mode))
      ple_pkg::MODE_PUSH: begin
        if (full) begin
          status = ple_pkg::STAT_FULL;
        end else begin
          ctrl.open_gap = 1'b1;
          count_d       = count_q + CNT_W'(1);
        end
      end
      ple_pkg::MODE_POP: begin
        if (empty) begin
          status = ple_pkg::STAT_EMPTY;
        end else begin
          ctrl.close_gap = 1'b1;
          count_d        = count_q - CNT_W'(1);
        end
      end
      ple_pkg::MODE_READ: begin
        at = pos_at;
        if (!in_range) begin
          status = ple_pkg::STAT_RANGE;
        end else begin
          do_read = 1'b1;
        end
      end
      ple_pkg::MODE_INSERT: begin
        at = pos_at;
        if (!in_range) begin
          status = ple_pkg::STAT_RANGE;
        end else if (full) begin
          status = ple_pkg::STAT_FULL;
        end else begin
          ctrl.open_gap = 1'b1;
          count_d       = count_q + CNT_W'(1);
        end
      end
      ple_pkg::MODE_DELETE: begin
        at = pos_at;
        if (!in_range) begin
          status = ple_pkg::STAT_RANGE;
        end else begin
          ctrl.close_gap = 1'b1;
          count_d        = count_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctrl.open_gap  = 1'b0;
      ctrl.close_gap = 1'b0;
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [ple_pkg::DATA_W-1:0] left;
    logic signed [ple_pkg::DATA_W-1:0] right;

    if (k == 0) begin : g_first
      assign left = req_i.value;
    end else begin : g_inner_left
      assign left = cell_data[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right = cell_data[k];
    end else begin : g_inner_right
      assign right = cell_data[k+1];
    end

    ple_cell #(
      .AT_W  (AT_W),
      .INDEX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .at_i    (at),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[k]),
      .rd_o    (cell_rd[k])
    );
  end

  always_comb begin
    read_bus = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      read_bus = read_bus | cell_rd[k];
    end
  end

  assign read_value = do_read ? read_bus : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_value_q  <= read_value;
      rsp_status_q <= status;
      rsp_count_q  <= ple_pkg::CNT_OUT_W'(count_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_value  = rsp_value_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.entry_count = rsp_count_q;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Sends push, pop, read, insert and delete requests through the request
// channel. The testbench keeps its own copy of the list to predict each
// response, and it compares every response field with the oldest prediction.
// Both channels idle at random, and the response side holds off for a long
// stretch once so that the engine has to stall its request side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned IDLE_PCT     = 36;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam longint      CYCLE_LIMIT  = 400000;
  localparam int unsigned POS_MAX      = (1 << ple_pkg::POS_W) - 1;

  localparam logic [ple_pkg::MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [ple_pkg::MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  localparam logic signed [ple_pkg::DATA_W-1:0] WORD_MIN =
    {1'b1, {(ple_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [ple_pkg::DATA_W-1:0] WORD_MAX =
    {1'b0, {(ple_pkg::DATA_W-1){1'b1}}};

  typedef struct packed {
    logic signed [ple_pkg::DATA_W-1:0] read_value;
    ple_pkg::status_e                  status;
    logic [ple_pkg::CNT_OUT_W-1:0]     entry_count;
  } list_rsp_t;

  logic clk_i;
  logic rst_ni;

  ple_req_if req_if ();
  ple_rsp_if rsp_if ();

  positional_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  logic signed [ple_pkg::DATA_W-1:0] list_words [CAPACITY];
  int unsigned                       list_count;
  list_rsp_t                         pending_rsps [$];
  int unsigned                       mismatches;
  int unsigned                       req_idle_pct;
  int unsigned                       rsp_idle_pct;
  int unsigned                       hold_left;
  longint                            cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void open_gap(input int unsigned at);
    for (int unsigned i = list_count; i > at; i--) list_words[i] = list_words[i-1];
  endfunction

  function automatic void close_gap(input int unsigned at);
    for (int unsigned i = at; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
  endfunction

  function automatic list_rsp_t apply_request(input logic [ple_pkg::MODE_W-1:0] mode,
                                              input logic [ple_pkg::POS_W-1:0] pos,
                                              input logic signed [ple_pkg::DATA_W-1:0] val);
    list_rsp_t rsp;
    bit        in_range;
    rsp.read_value = '0;
    rsp.status     = ple_pkg::STAT_OK;
    in_range       = (pos >= 1) && (pos <= list_count);
    case (mode)
      ple_pkg::MODE_PUSH: begin
        if (list_count >= CAPACITY) begin
          rsp.status = ple_pkg::STAT_FULL;
        end else begin
          open_gap(0);
          list_words[0] = val;
          list_count++;
        end
      end
      ple_pkg::MODE_POP: begin
        if (list_count == 0) begin
          rsp.status = ple_pkg::STAT_EMPTY;
        end else begin
          close_gap(0);
          list_count--;
        end
      end
      ple_pkg::MODE_READ: begin
        if (!in_range) rsp.status = ple_pkg::STAT_RANGE;
        else rsp.read_value = list_words[pos-1];
      end
      ple_pkg::MODE_INSERT: begin
        if (!in_range) begin
          rsp.status = ple_pkg::STAT_RANGE;
        end else if (list_count >= CAPACITY) begin
          rsp.status = ple_pkg::STAT_FULL;
        end else begin
          open_gap(pos - 1);
          list_words[pos-1] = val;
          list_count++;
        end
      end
      ple_pkg::MODE_DELETE: begin
        if (!in_range) begin
          rsp.status = ple_pkg::STAT_RANGE;
        end else begin
          close_gap(pos - 1);
          list_count--;
        end
      end
      default: begin
      end
    endcase
    rsp.entry_count = list_count[ple_pkg::CNT_OUT_W-1:0];
    return rsp;
  endfunction

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_rsp
    list_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected response: value %0d status %0d count %0d",
                   rsp_if.read_value, rsp_if.status, rsp_if.entry_count);
      end else begin
        want = pending_rsps.pop_front();
        if (rsp_if.read_value !== want.read_value || rsp_if.status !== want.status ||
            rsp_if.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"response mismatch: expected value %0d status %0d count %0d, ",
                      "got value %0d status %0d count %0d"},
                     want.read_value, want.status, want.entry_count,
                     rsp_if.read_value, rsp_if.status, rsp_if.entry_count);
        end
      end
    end
  end

  task automatic send_req(input logic [ple_pkg::MODE_W-1:0] mode,
                          input logic [ple_pkg::POS_W-1:0] pos,
                          input logic signed [ple_pkg::DATA_W-1:0] val);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= mode;
    req_if.position <= pos;
    req_if.value    <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_rsps.push_back(apply_request(mode, pos, val));
  endtask

  task automatic send_random_req(input int unsigned grow_pct);
    logic [ple_pkg::MODE_W-1:0]        mode;
    logic [ple_pkg::POS_W-1:0]         pos;
    logic signed [ple_pkg::DATA_W-1:0] val;
    int unsigned                       pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      mode = ple_pkg::MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    end else if (pick < 24) begin
      mode = ple_pkg::MODE_READ;
    end else if (pick < 24 + grow_pct) begin
      mode = $urandom_range(0, 1) ? ple_pkg::MODE_PUSH : ple_pkg::MODE_INSERT;
    end else begin
      mode = $urandom_range(0, 1) ? ple_pkg::MODE_POP : ple_pkg::MODE_DELETE;
    end
    if ($urandom_range(0, 9) == 0 || list_count == 0)
      pos = ple_pkg::POS_W'($urandom_range(0, POS_MAX));
    else pos = ple_pkg::POS_W'($urandom_range(1, list_count));
    case ($urandom_range(0, 15))
      0:       val = WORD_MIN;
      1:       val = WORD_MAX;
      2:       val = '0;
      3:       val = '1;
      default: val = $urandom;
    endcase
    send_req(mode, pos, val);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_list();
    send_req(ple_pkg::MODE_POP, 5'd1, '0);
    send_req(ple_pkg::MODE_READ, 5'd1, '0);
    send_req(ple_pkg::MODE_INSERT, 5'd1, WORD_MAX);
  endtask

  task automatic test_sole_entry();
    send_req(ple_pkg::MODE_PUSH, 5'd0, WORD_MIN);
    send_req(ple_pkg::MODE_DELETE, 5'd1, '0);
    send_req(ple_pkg::MODE_PUSH, 5'd0, WORD_MAX);
    send_req(ple_pkg::MODE_POP, 5'd0, '0);
  endtask

  task automatic test_full_list();
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      case (i)
        0:       send_req(ple_pkg::MODE_PUSH, 5'd0, WORD_MIN);
        1:       send_req(ple_pkg::MODE_PUSH, 5'd0, WORD_MAX);
        2:       send_req(ple_pkg::MODE_PUSH, 5'd0, '1);
        default: send_req(ple_pkg::MODE_PUSH, ple_pkg::POS_W'(POS_MAX), $urandom);
      endcase
    end
    send_req(ple_pkg::MODE_PUSH, 5'd0, '1);
    send_req(ple_pkg::MODE_INSERT, 5'd1, WORD_MAX);
    send_req(ple_pkg::MODE_INSERT, ple_pkg::POS_W'(CAPACITY + 1), WORD_MIN);
    send_req(ple_pkg::MODE_READ, ple_pkg::POS_W'(CAPACITY), '0);
    send_req(ple_pkg::MODE_READ, 5'd0, '0);
    send_req(ple_pkg::MODE_DELETE, ple_pkg::POS_W'(CAPACITY), '0);
    send_req(ple_pkg::MODE_INSERT, ple_pkg::POS_W'(CAPACITY), '1);
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned grow_pct);
    repeat (n) send_random_req(grow_pct);
  endtask

  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    test_random_traffic(30, 38);
  endtask

  task automatic test_drain_pause();
    wait_drained();
    test_random_traffic(100, 45);
  endtask

  task automatic test_no_idle();
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    test_random_traffic(300, 38);
    req_idle_pct = IDLE_PCT;
    rsp_idle_pct = IDLE_PCT;
  endtask

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.mode     = ple_pkg::MODE_PUSH;
    req_if.position = '0;
    req_if.value    = '0;
    list_count      = 0;
    mismatches      = 0;
    cycles          = 0;
    hold_left       = 0;
    req_idle_pct    = IDLE_PCT;
    rsp_idle_pct    = IDLE_PCT;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_sole_entry();
    test_full_list();
    test_random_traffic(400, 38);
    test_random_traffic(200, 60);
    test_backpressure();
    test_random_traffic(200, 20);
    test_drain_pause();
    test_no_idle();
    test_random_traffic(400, 38);

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ple_pkg.sv
design/ple_if.sv
design/ple_cell.sv
design/positional_list_engine_unit.sv
sim/testbench.sv
